// ===== hdl/apf_pkg.sv =====
// ----------------------------------------------------------------------------
// Audio playback FIFO package
// Shared constants, command codes and state type of the playback FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package apf_pkg;

   localparam int FifoFrames  = 4096;
   localparam int FadeLength  = 64;
   localparam int FadeShift   = $clog2(FadeLength);
   localparam int IdxW        = 13;
   localparam int AddrW       = 12;
   localparam int FadeW       = 7;

   localparam logic [15:0] VolUnity    = 16'd32768;
   localparam logic [1:0]  ChanReset   = 2'd2;
   localparam logic [12:0] PrebufReset = 13'd2048;

   localparam logic [2:0] CMD_PUSH   = 3'd0;
   localparam logic [2:0] CMD_RENDER = 3'd1;
   localparam logic [2:0] CMD_PLAY   = 3'd2;
   localparam logic [2:0] CMD_STOP   = 3'd3;
   localparam logic [2:0] CMD_PAUSE  = 3'd4;
   localparam logic [2:0] CMD_FLUSH  = 3'd5;

   localparam logic [2:0] FMT_U8  = 3'd0;
   localparam logic [2:0] FMT_S16 = 3'd1;
   localparam logic [2:0] FMT_S24 = 3'd2;
   localparam logic [2:0] FMT_S32 = 3'd3;
   localparam logic [2:0] FMT_F32 = 3'd4;

   localparam logic [1:0] REG_FORMAT   = 2'd0;
   localparam logic [1:0] REG_CHANNELS = 2'd1;
   localparam logic [1:0] REG_VOLUME   = 2'd2;
   localparam logic [1:0] REG_PREBUF   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_MUL,
      ST_DONE
   } state_type;

   function automatic logic signed [23:0] float_to_q23(input logic [31:0] raw);
      logic        neg;
      logic [7:0]  e;
      logic [23:0] m;
      logic [7:0]  sh;
      logic [24:0] q;
      neg = raw[31];
      e   = raw[30:23];
      m   = {1'b0, raw[22:0]};
      q   = '0;
      sh  = '0;
      if (e == 8'd255 && raw[22:0] != 23'd0) begin
         float_to_q23 = '0;
      end else if (e >= 8'd127) begin
         float_to_q23 = neg ? 24'sh800000 : 24'sh7fffff;
      end else begin
         if (e == 8'd0) begin
            sh = 8'd126;
         end else begin
            m  = {1'b1, raw[22:0]};
            sh = 8'd127 - e;
         end
         if (sh < 8'd25) begin
            q = 25'(({1'b0, m} + (25'd1 << (sh - 8'd1))) >> sh);
         end
         if (!neg && q > 25'h7fffff) begin
            q = 25'h7fffff;
         end
         float_to_q23 = neg ? 24'(-q) : q[23:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/audio_playback_fifo_core.sv =====
// ----------------------------------------------------------------------------
// Audio playback FIFO core
// Sample FIFO with format conversion, prebuffering, fades and volume.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel: push, render, play, stop, pause or
// flush, with block_start on req_tuser. Every request gives exactly one
// response on the rsp_ channel. The block takes one request at a time and
// req_tready is high only while it is idle. A push, a control request or a
// silent render updates the state in ST_EXEC, and rsp_tvalid is raised in
// ST_DONE, which follows ST_EXEC. An audible render then loads the frame from
// the registered sample memory and runs it through one shared multiplier,
// two passes for volume and two more during a fade, in ST_LOAD and then
// ST_MUL, before rsp_tvalid is raised in ST_DONE. The block returns to idle
// and is ready again once the response is taken. A stalled receiver holds
// the response and the block.
// Reset returns the control state and the configuration registers to their
// defaults; the sample memory is not cleared, since only written entries are
// ever read. The csr_ port writes a register at any edge with csr_wr_en high
// and is meant to be used only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_playback_fifo_core
   import apf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // command, sample_left, sample_right, pad
   input  wire logic        req_tuser,   // block_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // out_left, out_right, accepted,
                                         // fill_frames, underrun_total,
                                         // is_playing, pad
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [2:0]  fmt_ff;
   logic [1:0]  chan_ff;
   logic [15:0] vol_ff;
   logic [12:0] prebuf_ff;

   logic [IdxW-1:0]  wr_idx_ff, wr_idx_in, rd_idx_ff, rd_idx_in;
   logic             running_ff, running_in, prebuf_on_ff, prebuf_on_in;
   logic             half_ff, half_in, flush_pend_ff, flush_pend_in;
   logic             silent_ff, silent_in, urun_seen_ff, urun_seen_in;
   logic [FadeW-1:0] fade_ff, fade_in;
   logic [15:0]      urun_ff, urun_in;

   logic [2:0]  cmd_ff;
   logic [31:0] raw_l_ff, raw_r_ff;
   logic        first_ff;

   logic               accepted_ff, read_ok_ff;
   logic [15:0]        fade_gain_ff;
   logic [1:0]         step_ff;
   logic signed [23:0] s_l_ff, s_r_ff;

   logic stored_in, audible_in, read_ok_in, fade_on_in;

   logic            accept, exec;
   logic [IdxW-1:0] fill, thresh;
   logic            stereo;

   assign accept = req_tvalid && req_tready;
   assign exec   = (state_ff == ST_EXEC);
   assign fill   = wr_idx_ff - rd_idx_ff;
   assign stereo = chan_ff >= 2'd2;
   assign thresh = (prebuf_ff > IdxW'(FifoFrames)) ? IdxW'(FifoFrames) : prebuf_ff;

   function automatic logic signed [23:0] conv(input logic [2:0] f,
                                               input logic [31:0] raw);
      case (f)
         FMT_U8:  conv = {raw[7:0] ^ 8'h80, 16'h0};
         FMT_S24: conv = raw[23:0];
         FMT_S32: conv = raw[31:8];
         FMT_F32: conv = float_to_q23(raw);
         default: conv = {raw[15:0], 8'h0};
      endcase
   endfunction

   logic signed [23:0] wr_l, wr_r;
   logic [47:0]        ram_rd;
   logic               ram_we;
   assign wr_l   = conv(fmt_ff, raw_l_ff);
   assign wr_r   = stereo ? conv(fmt_ff, raw_r_ff) : 24'sd0;
   assign ram_we = exec && (cmd_ff == CMD_PUSH) && (fill < IdxW'(FifoFrames));

   apf_ram #(.Width(48), .Depth(FifoFrames)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff[AddrW-1:0]),
      .wr_data ({wr_r, wr_l}),
      .rd_addr (rd_idx_ff[AddrW-1:0]),
      .rd_data (ram_rd)
   );

   // Fade gain is the fade position over FadeLength, in Q1.15; a pause fades only to half gain.
   logic [23:0] fade_num;
   logic [15:0] fade_gain;
   assign fade_num  = half_ff ? 24'(FadeLength) + 24'(fade_ff) : 24'(fade_ff);
   assign fade_gain = half_ff ? 16'((fade_num << 15) >> (FadeShift + 1))
                              : 16'((fade_num << 15) >> FadeShift);

   // Shared multiplier: step bit 0 picks the channel, bit 1 picks volume.
   logic signed [23:0] mul_a, mul_res;
   logic [15:0]        mul_gain, vol_eff;
   logic signed [40:0] prod;
   assign vol_eff  = (vol_ff > VolUnity) ? VolUnity : vol_ff;
   assign mul_a    = step_ff[0] ? s_r_ff : s_l_ff;
   assign mul_gain = step_ff[1] ? vol_eff : fade_gain_ff;
   assign prod     = 41'(mul_a) * 41'($signed({1'b0, mul_gain}));
   assign mul_res  = 24'(prod >>> 15);

   always_comb begin
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      running_in    = running_ff;
      prebuf_on_in  = prebuf_on_ff;
      half_in       = half_ff;
      flush_pend_in = flush_pend_ff;
      silent_in     = silent_ff;
      urun_seen_in  = urun_seen_ff;
      fade_in       = fade_ff;
      urun_in       = urun_ff;
      stored_in     = 1'b0;
      audible_in    = 1'b0;
      read_ok_in    = 1'b0;
      fade_on_in    = 1'b0;
      if (exec) begin
         case (cmd_ff)
            CMD_PUSH: begin
               if (ram_we) begin
                  wr_idx_in = wr_idx_ff + IdxW'(1);
                  stored_in = 1'b1;
               end
            end
            CMD_RENDER: begin
               if (first_ff) begin
                  urun_seen_in = 1'b0;
                  silent_in    = 1'b0;
                  if (running_ff && prebuf_on_ff) begin
                     if (fill < thresh) begin
                        silent_in = 1'b1;
                     end else begin
                        prebuf_on_in = 1'b0;
                     end
                  end
               end
               if (running_ff && !silent_in) begin
                  audible_in = 1'b1;
                  fade_on_in = fade_ff != '0;
                  if (fill != '0) begin
                     rd_idx_in  = rd_idx_ff + IdxW'(1);
                     read_ok_in = 1'b1;
                  end else if (fade_ff == '0 && !urun_seen_in) begin
                     urun_seen_in = 1'b1;
                     if (urun_ff != 16'hffff) begin
                        urun_in = urun_ff + 16'd1;
                     end
                  end
               end
               if (running_ff && fade_ff != '0) begin
                  fade_in = fade_ff - FadeW'(1);
                  if (fade_ff == FadeW'(1)) begin
                     running_in = 1'b0;
                     half_in    = 1'b0;
                     if (flush_pend_ff) begin
                        wr_idx_in     = '0;
                        rd_idx_in     = '0;
                        prebuf_on_in  = 1'b0;
                        flush_pend_in = 1'b0;
                     end
                  end
               end
            end
            CMD_PLAY: begin
               fade_in       = '0;
               half_in       = 1'b0;
               flush_pend_in = 1'b0;
               prebuf_on_in  = 1'b1;
               running_in    = 1'b1;
               silent_in     = 1'b1;
            end
            CMD_STOP: begin
               if (running_ff) begin
                  fade_in       = FadeW'(FadeLength);
                  half_in       = 1'b0;
                  flush_pend_in = 1'b1;
               end else begin
                  wr_idx_in    = '0;
                  rd_idx_in    = '0;
                  prebuf_on_in = 1'b0;
               end
            end
            CMD_PAUSE: begin
               if (running_ff) begin
                  fade_in = FadeW'(FadeLength);
                  half_in = 1'b1;
               end
            end
            CMD_FLUSH: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = audible_in ? ST_LOAD : ST_DONE;
         ST_LOAD: state_in = ST_MUL;
         ST_MUL: begin
            if (step_ff == 2'd3) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_DONE);
      rsp_tdata  = {1'b0, running_ff, urun_ff, fill, accepted_ff, s_r_ff, s_l_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fmt_ff        <= FMT_S16;
         chan_ff       <= ChanReset;
         vol_ff        <= VolUnity;
         prebuf_ff     <= PrebufReset;
         wr_idx_ff     <= '0;
         rd_idx_ff     <= '0;
         running_ff    <= 1'b0;
         prebuf_on_ff  <= 1'b0;
         half_ff       <= 1'b0;
         flush_pend_ff <= 1'b0;
         silent_ff     <= 1'b0;
         urun_seen_ff  <= 1'b0;
         fade_ff       <= '0;
         urun_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         wr_idx_ff     <= wr_idx_in;
         rd_idx_ff     <= rd_idx_in;
         running_ff    <= running_in;
         prebuf_on_ff  <= prebuf_on_in;
         half_ff       <= half_in;
         flush_pend_ff <= flush_pend_in;
         silent_ff     <= silent_in;
         urun_seen_ff  <= urun_seen_in;
         fade_ff       <= fade_in;
         urun_ff       <= urun_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_FORMAT:   fmt_ff    <= csr_wdata[2:0];
               REG_CHANNELS: chan_ff   <= csr_wdata[1:0];
               REG_VOLUME:   vol_ff    <= csr_wdata;
               REG_PREBUF:   prebuf_ff <= csr_wdata[12:0];
               default:      ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tdata[2:0];
         raw_l_ff <= req_tdata[34:3];
         raw_r_ff <= req_tdata[66:35];
         first_ff <= req_tuser;
      end
      if (exec) begin
         accepted_ff  <= stored_in;
         read_ok_ff   <= read_ok_in;
         fade_gain_ff <= fade_gain;
         step_ff      <= fade_on_in ? 2'd0 : 2'd2;
         s_l_ff       <= '0;
         s_r_ff       <= '0;
      end
      if (state_ff == ST_LOAD) begin
         s_l_ff <= read_ok_ff ? ram_rd[23:0] : 24'd0;
         s_r_ff <= (read_ok_ff && stereo) ? ram_rd[47:24] : 24'd0;
      end
      if (state_ff == ST_MUL) begin
         step_ff <= step_ff + 2'd1;
         if (step_ff[0]) begin
            s_r_ff <= mul_res;
         end else begin
            s_l_ff <= mul_res;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/apf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apf_ram #(
   parameter int Width = 24,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
